// ===== hdl/maf_pkg.sv =====
// ============================================================================
// maf_pkg : moving average filter shared definitions
// Widths, limits, controller states and divider handshake types.
// ============================================================================
package maf_pkg;

  localparam int MAX_WINDOW  = 64;
  localparam int SAMPLE_BITS = 16;
  localparam int WIN_BITS    = $clog2(MAX_WINDOW + 1);
  localparam int POS_BITS    = $clog2(MAX_WINDOW);
  localparam int SUM_BITS    = SAMPLE_BITS + POS_BITS;
  localparam int CNT_BITS    = $clog2(SUM_BITS);

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic signed [SUM_BITS-1:0]    sum_t;
  typedef logic [WIN_BITS-1:0]           win_t;
  typedef logic [POS_BITS-1:0]           pos_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_UPDATE,
    ST_DIVIDE,
    ST_FINISH
  } maf_state_t;

  // request from controller to the serial divider
  typedef struct packed {
    logic start;
    sum_t dividend;
    win_t divisor;
  } div_req_t;

  // divider status back to the controller
  typedef struct packed {
    logic    done;
    sample_t quotient;
  } div_rsp_t;

endpackage

// ===== hdl/maf_in_if.sv =====
// ============================================================================
// maf_in_if : sample input channel
// Valid/ready channel carrying one Q8.8 sample per transfer.
// ============================================================================
interface maf_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [maf_pkg::SAMPLE_BITS-1:0] sample_in;

  modport source (output valid, output sample_in, input ready);
  modport sink   (input valid, input sample_in, output ready);
endinterface

// ===== hdl/maf_out_if.sv =====
// ============================================================================
// maf_out_if : mean output channel
// Valid/ready channel carrying one Q8.8 mean per transfer.
// ============================================================================
interface maf_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [maf_pkg::SAMPLE_BITS-1:0] mean_out;

  modport source (output valid, output mean_out, input ready);
  modport sink   (input valid, input mean_out, output ready);
endinterface

// ===== hdl/moving_average_filter_unit.sv =====
// ============================================================================
// moving_average_filter_unit : boxcar moving average
// Returns the truncated mean of the last window_size Q8.8 samples.
// ============================================================================
// Each input transfer yields exactly one output transfer. With window_size
// zero the sample is loaded straight into the output register at its
// transfer edge. Otherwise the sample is written into the sample ring, and the
// entry it replaces is fetched, at the transfer edge itself. The controller
// then moves through ST_UPDATE, which updates the running sum and write
// position and starts the bit-serial divider, ST_DIVIDE, in which the divider
// works through the 22-bit sum one quotient bit per cycle and then raises its
// registered done flag, and ST_FINISH, which loads the output register once it
// is free. The block takes the next sample once the result sits in the output
// register, not before, and a slow consumer leaves at most one finished mean
// waiting in the output register while the next sample is averaged. A cfg_we
// write saturates the value to 64 and restarts averaging with an empty window;
// it must only occur while the block is idle.
// No clearing pass follows reset: entries of the ring are only used after
// having been written since the last restart.
// ============================================================================
module moving_average_filter_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  maf_in_if.sink                        in_ch,
  maf_out_if.source                     out_ch,
  input  logic                          cfg_we,
  input  logic [maf_pkg::WIN_BITS-1:0]  cfg_data
);
  import maf_pkg::*;

  // controller state
  maf_state_t state_r, state_nxt;

  // filter state
  win_t    window_r;
  pos_t    pos_r;
  logic    filled_r;
  sum_t    sum_r;

  // per-sample working registers
  sample_t sample_r;
  sample_t old_r;

  // output register
  logic    out_valid_r;
  sample_t mean_r;

  // sample ring
  sample_t ring_mem [MAX_WINDOW];

  div_req_t div_req;
  div_rsp_t div_rsp;

  logic    pass;
  logic    in_xfer;
  logic    out_free;
  logic    load_div;

  // update-step values
  logic [WIN_BITS-1:0] pos_inc;
  logic                wrap;
  pos_t                pos_upd;
  logic                filled_upd;
  sum_t                old_ext;
  sum_t                smp_ext;
  sum_t                sum_upd;
  win_t                count;

  assign pass     = (window_r == '0);
  // output register is free or emptied at this edge
  assign out_free = !out_valid_r || out_ch.ready;

  // next state and handshake
  always_comb begin
    state_nxt   = state_r;
    in_ch.ready = 1'b0;
    load_div    = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ch.ready = pass ? out_free : 1'b1;
        if (in_ch.valid && !pass) begin
          state_nxt = ST_UPDATE;
        end
      end
      ST_UPDATE: state_nxt = ST_DIVIDE;
      ST_DIVIDE: begin
        if (div_rsp.done) begin
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          load_div  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign in_xfer = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // update step: drop oldest sample once full, add new, advance position
  always_comb begin
    pos_inc    = {1'b0, pos_r} + 1'b1;
    wrap       = (pos_inc >= window_r);
    pos_upd    = wrap ? '0 : pos_inc[POS_BITS-1:0];
    filled_upd = filled_r || wrap;
    old_ext    = filled_r ? SUM_BITS'(old_r) : '0;
    smp_ext    = SUM_BITS'(sample_r);
    sum_upd    = sum_r - old_ext + smp_ext;
    count      = filled_upd ? window_r : pos_inc;
  end

  assign div_req.start    = (state_r == ST_UPDATE);
  assign div_req.dividend = sum_upd;
  assign div_req.divisor  = count;

  maf_divider u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // window config and filter state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_r <= '0;
      pos_r    <= '0;
      filled_r <= 1'b0;
      sum_r    <= '0;
    end else if (cfg_we) begin
      window_r <= (cfg_data > WIN_BITS'(MAX_WINDOW)) ? WIN_BITS'(MAX_WINDOW) : cfg_data;
      pos_r    <= '0;
      filled_r <= 1'b0;
      sum_r    <= '0;
    end else if (state_r == ST_UPDATE) begin
      pos_r    <= pos_upd;
      filled_r <= filled_upd;
      sum_r    <= sum_upd;
    end
  end

  // ring: registered read of the entry being replaced, then overwrite
  always_ff @(posedge clk) begin
    if (in_xfer && !pass) begin
      old_r           <= ring_mem[pos_r];
      ring_mem[pos_r] <= in_ch.sample_in;
      sample_r        <= in_ch.sample_in;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if ((in_xfer && pass) || load_div) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer && pass) begin
      mean_r <= in_ch.sample_in;
    end else if (load_div) begin
      mean_r <= div_rsp.quotient;
    end
  end

  assign out_ch.valid    = out_valid_r;
  assign out_ch.mean_out = mean_r;

endmodule

// ===== hdl/maf_divider.sv =====
// ============================================================================
// maf_divider : bit-serial signed divider
// Restoring division of the running sum by the sample count, one quotient
// bit per cycle, quotient truncated toward zero.
// ============================================================================
module maf_divider (
  input  logic              clk,
  input  logic              rst_n,
  input  maf_pkg::div_req_t req,
  output maf_pkg::div_rsp_t rsp
);
  import maf_pkg::*;

  logic                busy_r;
  logic                done_r;
  logic [CNT_BITS-1:0] cnt_r;
  logic [SUM_BITS-1:0] dvd_r;
  logic [WIN_BITS-1:0] rem_r;
  win_t                div_r;
  logic                neg_r;
  sample_t             quo_r;

  logic [WIN_BITS:0]   shifted;
  logic                ge;
  logic [WIN_BITS:0]   diff;
  logic [SUM_BITS-1:0] q_final;
  logic [SUM_BITS-1:0] q_signed;
  logic [SUM_BITS-1:0] mag;

  always_comb begin
    shifted  = {rem_r, dvd_r[SUM_BITS-1]};
    ge       = (shifted >= {1'b0, div_r});
    diff     = shifted - {1'b0, div_r};
    q_final  = {dvd_r[SUM_BITS-2:0], ge};
    q_signed = neg_r ? (SUM_BITS'(0) - q_final) : q_final;
    mag      = req.dividend[SUM_BITS-1] ? (SUM_BITS'(0) - req.dividend) : req.dividend;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_BITS'(SUM_BITS - 1);
      end else if (busy_r) begin
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          cnt_r <= cnt_r - 1'b1;
        end
      end
    end
  end

  // datapath, no reset
  always_ff @(posedge clk) begin
    if (req.start) begin
      neg_r <= req.dividend[SUM_BITS-1];
      dvd_r <= mag;
      rem_r <= '0;
      div_r <= req.divisor;
    end else if (busy_r) begin
      rem_r <= ge ? diff[WIN_BITS-1:0] : shifted[WIN_BITS-1:0];
      dvd_r <= q_final;
      if (cnt_r == '0) begin
        quo_r <= q_signed[SAMPLE_BITS-1:0];
      end
    end
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = quo_r;

endmodule

// ===== hdl/maf_checker.sv =====
// ============================================================================
// maf_checker : port-level checks for the moving average filter
// Tracks outstanding transfers and checks output stability, their bound and pass-through.
// ============================================================================
module maf_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic [maf_pkg::SAMPLE_BITS-1:0] sample_in,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [maf_pkg::SAMPLE_BITS-1:0] mean_out,
  input logic                          cfg_we,
  input logic [maf_pkg::WIN_BITS-1:0]  cfg_data
);
  import maf_pkg::*;

  logic       in_xfer;
  logic       out_xfer;
  logic [1:0] pend_r;
  logic       wzero_r;

  assign in_xfer  = in_valid && in_ready;
  assign out_xfer = out_valid && out_ready;

  // samples taken whose mean has not been transferred yet
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else if (in_xfer && !out_xfer) begin
      pend_r <= pend_r + 1'b1;
    end else if (out_xfer && !in_xfer) begin
      pend_r <= pend_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wzero_r <= 1'b1;
    end else if (cfg_we) begin
      wzero_r <= (cfg_data == '0);
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(mean_out))
    else $error("mean dropped or changed while stalled");

  a_no_extra: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> pend_r != 2'd0)
    else $error("result without a pending sample");

  a_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r != 2'd3)
    else $error("too many samples outstanding");

  a_pass: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer && wzero_r && !cfg_we |=> out_valid && mean_out == $past(sample_in))
    else $error("pass-through mismatch");

endmodule

bind moving_average_filter_unit maf_checker u_maf_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .sample_in (in_ch.sample_in),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .mean_out  (out_ch.mean_out),
  .cfg_we    (cfg_we),
  .cfg_data  (cfg_data)
);
